### hw/rtl/c6502_pkg.sv
// shared types and operation codes of the 6502 execute unit
package c6502_pkg;

    typedef enum logic [5:0] {
        OP_LDA = 6'd0,  OP_LDX = 6'd1,  OP_LDY = 6'd2,  OP_STA = 6'd3,
        OP_STX = 6'd4,  OP_STY = 6'd5,  OP_TAX = 6'd6,  OP_TAY = 6'd7,
        OP_TXA = 6'd8,  OP_TYA = 6'd9,  OP_TSX = 6'd10, OP_TXS = 6'd11,
        OP_PHA = 6'd12, OP_PHP = 6'd13, OP_PLA = 6'd14, OP_PLP = 6'd15,
        OP_AND = 6'd16, OP_EOR = 6'd17, OP_ORA = 6'd18, OP_BIT = 6'd19,
        OP_ADC = 6'd20, OP_SBC = 6'd21, OP_CMP = 6'd22, OP_CPX = 6'd23,
        OP_CPY = 6'd24, OP_INC = 6'd25, OP_INX = 6'd26, OP_INY = 6'd27,
        OP_DEC = 6'd28, OP_DEX = 6'd29, OP_DEY = 6'd30, OP_ASL = 6'd31,
        OP_LSR = 6'd32, OP_ROL = 6'd33, OP_ROR = 6'd34, OP_JMP = 6'd35,
        OP_JSR = 6'd36, OP_RTS = 6'd37, OP_BCC = 6'd38, OP_BCS = 6'd39,
        OP_BEQ = 6'd40, OP_BMI = 6'd41, OP_BNE = 6'd42, OP_BPL = 6'd43,
        OP_BVC = 6'd44, OP_BVS = 6'd45, OP_CLC = 6'd46, OP_CLD = 6'd47,
        OP_CLI = 6'd48, OP_CLV = 6'd49, OP_SEC = 6'd50, OP_SED = 6'd51,
        OP_SEI = 6'd52, OP_BRK = 6'd53, OP_NOP = 6'd54, OP_RTI = 6'd55
    } op_t;

    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_I = 2;
    localparam int FLAG_D = 3;
    localparam int FLAG_B = 4;
    localparam int FLAG_U = 5;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    localparam logic [7:0] STACK_PAGE = 8'h01;
    localparam logic [7:0] SP_RESET   = 8'hFD;
    localparam logic [7:0] P_RESET    = 8'h24;

    typedef struct packed {
        logic [7:0]  acc;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  sp;
        logic [15:0] pc;
        logic [7:0]  p;
    } regs_t;

    // up to three writes of one instruction
    typedef struct packed {
        logic [1:0]  count;
        logic [15:0] addr0;
        logic [7:0]  data0;
        logic [15:0] addr1;
        logic [7:0]  data1;
        logic [15:0] addr2;
        logic [7:0]  data2;
    } wr_set_t;

endpackage

### hw/rtl/cpu6502_execute_unit.sv
// top level of the 6502 execute unit: register state, result sequencer
//
//  channel | dir | tdata fields (low bit up)                        | tuser / tlast
//  s_      | in  | cmd, acc_mode, operand_value, eff_addr, next_pc,  | -
//          |     | stack_b1, stack_b2, stack_b3, irq_vector (88b)    |
//  m_      | out | write_valid, write_addr, write_data, pc_out,      | tlast = last
//          |     | acc_out, x_out, y_out, sp_out, status_out (88b)   |
//
// each request is executed in the cycle it is accepted; results are then
// emitted from a result register, one per cycle while m_tready is high, 1 to 3
// per request (number of memory writes, at least one). a new request is taken
// when idle or as the last result of the previous one is taken.
// reset (aresetn low, synchronous) loads the architectural reset state.
module cpu6502_execute_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // cmd[5:0] acc_mode[6] operand_value[14:7] eff_addr[30:15] next_pc[46:31]
    // stack_b1[54:47] stack_b2[62:55] stack_b3[70:63] irq_vector[86:71]
    input  logic [87:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // write_valid[0] write_addr[16:1] write_data[24:17] pc_out[40:25]
    // acc_out[48:41] x_out[56:49] y_out[64:57] sp_out[72:65] status_out[80:73]
    output logic [87:0]  m_tdata,
    output logic         m_tlast
);

    c6502_pkg::regs_t   regs_reg;
    c6502_pkg::regs_t   regs_next;
    c6502_pkg::wr_set_t wr_calc;
    c6502_pkg::wr_set_t wr_reg;
    logic               busy_reg;
    logic [1:0]         idx_reg;
    logic [1:0]         total;
    logic               out_last;
    logic               s_fire;
    logic               m_fire;
    logic               wv;
    logic [15:0]        wa;
    logic [7:0]         wd;

    c6502_alu u_alu (
        .cmd           (s_tdata[5:0]),
        .acc_mode      (s_tdata[6]),
        .operand_value (s_tdata[14:7]),
        .eff_addr      (s_tdata[30:15]),
        .next_pc       (s_tdata[46:31]),
        .stack_b1      (s_tdata[54:47]),
        .stack_b2      (s_tdata[62:55]),
        .stack_b3      (s_tdata[70:63]),
        .irq_vector    (s_tdata[86:71]),
        .cur           (regs_reg),
        .nxt           (regs_next),
        .wr            (wr_calc)
    );

    assign total    = (wr_reg.count == 2'd0) ? 2'd1 : wr_reg.count;
    assign out_last = (idx_reg == total - 2'd1);
    assign m_fire   = m_tvalid & m_tready;
    assign s_tready = ~busy_reg | (m_tready & out_last);
    assign s_fire   = s_tvalid & s_tready;
    assign m_tvalid = busy_reg;
    assign m_tlast  = out_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
            regs_reg <= '{acc: 8'd0, x: 8'd0, y: 8'd0, sp: c6502_pkg::SP_RESET,
                          pc: 16'd0, p: c6502_pkg::P_RESET};
        end else begin
            if (s_fire) begin
                busy_reg <= 1'b1;
                idx_reg  <= 2'd0;
                regs_reg <= regs_next;
                wr_reg   <= wr_calc;
            end else if (m_fire) begin
                if (out_last) busy_reg <= 1'b0;
                else idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_comb begin
        wv = (wr_reg.count != 2'd0);
        unique case (idx_reg)
            2'd0:    begin wa = wr_reg.addr0; wd = wr_reg.data0; end
            2'd1:    begin wa = wr_reg.addr1; wd = wr_reg.data1; end
            default: begin wa = wr_reg.addr2; wd = wr_reg.data2; end
        endcase
        if (!wv) begin
            wa = 16'd0;
            wd = 8'd0;
        end
    end

    assign m_tdata = {7'd0, regs_reg.p, regs_reg.sp, regs_reg.y, regs_reg.x,
                      regs_reg.acc, regs_reg.pc, wd, wa, wv};

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (idx_reg < total)) else $error("result index out of range");
    a_sp_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        regs_reg.p[c6502_pkg::FLAG_U] && !regs_reg.p[c6502_pkg::FLAG_B])
        else $error("status unused/break bits wrong");
    a_take_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && s_fire) |-> (m_fire && out_last))
        else $error("request taken before last result");

endmodule

### hw/rtl/c6502_alu.sv
// combinational next-state and write computation for one instruction
module c6502_alu (
    input  logic [5:0]          cmd,
    input  logic                acc_mode,
    input  logic [7:0]          operand_value,
    input  logic [15:0]         eff_addr,
    input  logic [15:0]         next_pc,
    input  logic [7:0]          stack_b1,
    input  logic [7:0]          stack_b2,
    input  logic [7:0]          stack_b3,
    input  logic [15:0]         irq_vector,
    input  c6502_pkg::regs_t    cur,
    output c6502_pkg::regs_t    nxt,
    output c6502_pkg::wr_set_t  wr
);

    logic [7:0]  m;
    logic [7:0]  p;
    logic [8:0]  sum;
    logic [7:0]  addm;
    logic [7:0]  sh_in;
    logic [7:0]  res;
    logic [8:0]  cmp_diff;
    logic [7:0]  cmp_reg;
    logic [15:0] ret_addr;
    logic [15:0] stk0;
    logic [15:0] stk1;
    logic [15:0] stk2;
    logic        taken;
    logic [7:0]  nz_val;
    logic        set_nz_en;

    assign m    = operand_value;
    assign p    = cur.p;
    assign addm = (cmd == c6502_pkg::OP_SBC) ? ~m : m;
    assign sum  = {1'b0, cur.acc} + {1'b0, addm} + {8'd0, p[c6502_pkg::FLAG_C]};
    assign sh_in = acc_mode ? cur.acc : m;
    assign stk0 = {c6502_pkg::STACK_PAGE, cur.sp};
    assign stk1 = {c6502_pkg::STACK_PAGE, cur.sp - 8'd1};
    assign stk2 = {c6502_pkg::STACK_PAGE, cur.sp - 8'd2};

    always_comb begin
        cmp_reg = cur.acc;
        if (cmd == c6502_pkg::OP_CPX) cmp_reg = cur.x;
        if (cmd == c6502_pkg::OP_CPY) cmp_reg = cur.y;
        cmp_diff = {1'b0, cmp_reg} - {1'b0, m};
    end

    always_comb begin
        nxt       = cur;
        nxt.pc    = next_pc;
        wr        = '0;
        res       = 8'd0;
        nz_val    = 8'd0;
        set_nz_en = 1'b0;
        taken     = 1'b0;
        ret_addr  = 16'd0;
        unique case (cmd)
            c6502_pkg::OP_LDA: begin nxt.acc = m; nz_val = m; set_nz_en = 1'b1; end
            c6502_pkg::OP_LDX: begin nxt.x = m; nz_val = m; set_nz_en = 1'b1; end
            c6502_pkg::OP_LDY: begin nxt.y = m; nz_val = m; set_nz_en = 1'b1; end
            c6502_pkg::OP_STA: begin wr.count = 2'd1; wr.addr0 = eff_addr; wr.data0 = cur.acc; end
            c6502_pkg::OP_STX: begin wr.count = 2'd1; wr.addr0 = eff_addr; wr.data0 = cur.x; end
            c6502_pkg::OP_STY: begin wr.count = 2'd1; wr.addr0 = eff_addr; wr.data0 = cur.y; end
            c6502_pkg::OP_TAX: begin nxt.x = cur.acc; nz_val = cur.acc; set_nz_en = 1'b1; end
            c6502_pkg::OP_TAY: begin nxt.y = cur.acc; nz_val = cur.acc; set_nz_en = 1'b1; end
            c6502_pkg::OP_TXA: begin nxt.acc = cur.x; nz_val = cur.x; set_nz_en = 1'b1; end
            c6502_pkg::OP_TYA: begin nxt.acc = cur.y; nz_val = cur.y; set_nz_en = 1'b1; end
            c6502_pkg::OP_TSX: begin nxt.x = cur.sp; nz_val = cur.sp; set_nz_en = 1'b1; end
            c6502_pkg::OP_TXS: nxt.sp = cur.x;
            c6502_pkg::OP_PHA: begin
                wr.count = 2'd1; wr.addr0 = stk0; wr.data0 = cur.acc; nxt.sp = cur.sp - 8'd1;
            end
            c6502_pkg::OP_PHP: begin
                wr.count = 2'd1; wr.addr0 = stk0; wr.data0 = p | 8'h30;
                nxt.sp = cur.sp - 8'd1;
            end
            c6502_pkg::OP_PLA: begin
                nxt.sp = cur.sp + 8'd1; nxt.acc = stack_b1; nz_val = stack_b1; set_nz_en = 1'b1;
            end
            c6502_pkg::OP_PLP: begin
                nxt.sp = cur.sp + 8'd1; nxt.p = (stack_b1 & 8'hEF) | 8'h20;
            end
            c6502_pkg::OP_AND: begin
                nxt.acc = cur.acc & m; nz_val = cur.acc & m; set_nz_en = 1'b1;
            end
            c6502_pkg::OP_EOR: begin
                nxt.acc = cur.acc ^ m; nz_val = cur.acc ^ m; set_nz_en = 1'b1;
            end
            c6502_pkg::OP_ORA: begin
                nxt.acc = cur.acc | m; nz_val = cur.acc | m; set_nz_en = 1'b1;
            end
            c6502_pkg::OP_BIT: begin
                nxt.p[c6502_pkg::FLAG_Z] = ((cur.acc & m) == 8'd0);
                nxt.p[c6502_pkg::FLAG_N] = m[7];
                nxt.p[c6502_pkg::FLAG_V] = m[6];
            end
            c6502_pkg::OP_ADC, c6502_pkg::OP_SBC: begin
                nxt.acc = sum[7:0];
                nxt.p[c6502_pkg::FLAG_C] = sum[8];
                nxt.p[c6502_pkg::FLAG_V] = ~(cur.acc[7] ^ addm[7]) & (cur.acc[7] ^ sum[7]);
                nz_val = sum[7:0]; set_nz_en = 1'b1;
            end
            c6502_pkg::OP_CMP, c6502_pkg::OP_CPX, c6502_pkg::OP_CPY: begin
                nz_val = cmp_diff[7:0]; set_nz_en = 1'b1;
                nxt.p[c6502_pkg::FLAG_C] = ~cmp_diff[8];
            end
            c6502_pkg::OP_INC, c6502_pkg::OP_DEC: begin
                res = (cmd == c6502_pkg::OP_INC) ? m + 8'd1 : m - 8'd1;
                nz_val = res; set_nz_en = 1'b1;
                wr.count = 2'd1; wr.addr0 = eff_addr; wr.data0 = res;
            end
            c6502_pkg::OP_INX: begin nxt.x = cur.x + 8'd1; nz_val = cur.x + 8'd1; set_nz_en = 1'b1; end
            c6502_pkg::OP_INY: begin nxt.y = cur.y + 8'd1; nz_val = cur.y + 8'd1; set_nz_en = 1'b1; end
            c6502_pkg::OP_DEX: begin nxt.x = cur.x - 8'd1; nz_val = cur.x - 8'd1; set_nz_en = 1'b1; end
            c6502_pkg::OP_DEY: begin nxt.y = cur.y - 8'd1; nz_val = cur.y - 8'd1; set_nz_en = 1'b1; end
            c6502_pkg::OP_ASL, c6502_pkg::OP_LSR, c6502_pkg::OP_ROL, c6502_pkg::OP_ROR: begin
                if (cmd == c6502_pkg::OP_ASL || cmd == c6502_pkg::OP_ROL) begin
                    res = {sh_in[6:0],
                           (cmd == c6502_pkg::OP_ROL) & p[c6502_pkg::FLAG_C]};
                    nxt.p[c6502_pkg::FLAG_C] = sh_in[7];
                end else begin
                    res = {(cmd == c6502_pkg::OP_ROR) & p[c6502_pkg::FLAG_C], sh_in[7:1]};
                    nxt.p[c6502_pkg::FLAG_C] = sh_in[0];
                end
                nz_val = res; set_nz_en = 1'b1;
                if (acc_mode) begin
                    nxt.acc = res;
                end else begin
                    wr.count = 2'd1; wr.addr0 = eff_addr; wr.data0 = res;
                end
            end
            c6502_pkg::OP_JMP: nxt.pc = eff_addr;
            c6502_pkg::OP_JSR: begin
                ret_addr = next_pc - 16'd1;
                wr.count = 2'd2;
                wr.addr0 = stk0; wr.data0 = ret_addr[15:8];
                wr.addr1 = stk1; wr.data1 = ret_addr[7:0];
                nxt.sp = cur.sp - 8'd2;
                nxt.pc = eff_addr;
            end
            c6502_pkg::OP_RTS: begin
                nxt.sp = cur.sp + 8'd2;
                nxt.pc = {stack_b2, stack_b1} + 16'd1;
            end
            c6502_pkg::OP_BCC: taken = ~p[c6502_pkg::FLAG_C];
            c6502_pkg::OP_BCS: taken = p[c6502_pkg::FLAG_C];
            c6502_pkg::OP_BEQ: taken = p[c6502_pkg::FLAG_Z];
            c6502_pkg::OP_BMI: taken = p[c6502_pkg::FLAG_N];
            c6502_pkg::OP_BNE: taken = ~p[c6502_pkg::FLAG_Z];
            c6502_pkg::OP_BPL: taken = ~p[c6502_pkg::FLAG_N];
            c6502_pkg::OP_BVC: taken = ~p[c6502_pkg::FLAG_V];
            c6502_pkg::OP_BVS: taken = p[c6502_pkg::FLAG_V];
            c6502_pkg::OP_CLC: nxt.p[c6502_pkg::FLAG_C] = 1'b0;
            c6502_pkg::OP_CLD: nxt.p[c6502_pkg::FLAG_D] = 1'b0;
            c6502_pkg::OP_CLI: nxt.p[c6502_pkg::FLAG_I] = 1'b0;
            c6502_pkg::OP_CLV: nxt.p[c6502_pkg::FLAG_V] = 1'b0;
            c6502_pkg::OP_SEC: nxt.p[c6502_pkg::FLAG_C] = 1'b1;
            c6502_pkg::OP_SED: nxt.p[c6502_pkg::FLAG_D] = 1'b1;
            c6502_pkg::OP_SEI: nxt.p[c6502_pkg::FLAG_I] = 1'b1;
            c6502_pkg::OP_BRK: begin
                ret_addr = next_pc + 16'd1;
                wr.count = 2'd3;
                wr.addr0 = stk0; wr.data0 = ret_addr[15:8];
                wr.addr1 = stk1; wr.data1 = ret_addr[7:0];
                wr.addr2 = stk2; wr.data2 = p | 8'h30;
                nxt.sp = cur.sp - 8'd3;
                nxt.p[c6502_pkg::FLAG_I] = 1'b1;
                nxt.pc = irq_vector;
            end
            c6502_pkg::OP_RTI: begin
                nxt.sp = cur.sp + 8'd3;
                nxt.p = (stack_b1 & 8'hEF) | 8'h20;
                nxt.pc = {stack_b3, stack_b2};
            end
            default: ;
        endcase
        if (set_nz_en) begin
            nxt.p[c6502_pkg::FLAG_Z] = (nz_val == 8'd0);
            nxt.p[c6502_pkg::FLAG_N] = nz_val[7];
        end
        if (taken) nxt.pc = eff_addr;
    end

endmodule

### sim/cpu6502_execute_unit_tb.sv
// testbench of the 6502 execute unit: directed and random instructions, checked
// against a built-in predictor of the register and memory-write behavior
`timescale 1ns / 100ps

module cpu6502_execute_unit_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 60;

    typedef struct packed {
        logic [15:0] vec;
        logic [7:0]  b3;
        logic [7:0]  b2;
        logic [7:0]  b1;
        logic [15:0] npc;
        logic [15:0] ea;
        logic [7:0]  m;
        logic        accm;
        logic [5:0]  cmd;
    } instr_t;

    typedef struct packed {
        logic [7:0]  p;
        logic [7:0]  sp;
        logic [7:0]  y;
        logic [7:0]  x;
        logic [7:0]  acc;
        logic [15:0] pc;
        logic [7:0]  wdata;
        logic [15:0] waddr;
        logic        wvalid;
        logic        last;
    } effect_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic        m_tlast;

    cpu6502_execute_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    always #5 aclk = ~aclk;

    instr_t  pending_instrs[$];
    effect_t expected_effects[$];
    int      error_count = 0;
    bit      calm = 0;
    bit      hold_req = 0;
    bit      hold_done = 0;
    bit      in_taken = 0;
    int      hold_off = 0;
    int      send_gap = 0;
    int      recv_gap = 0;

    // architectural state of the predictor
    logic [7:0]  cpu_a, cpu_x, cpu_y, cpu_sp, cpu_p;
    logic [15:0] cpu_pc;
    logic [15:0] wr_a[3];
    logic [7:0]  wr_d[3];
    int          wr_n;

    function automatic void put_nz(logic [7:0] v);
        cpu_p[c6502_pkg::FLAG_N] = v[7];
        cpu_p[c6502_pkg::FLAG_Z] = (v == 8'h00);
    endfunction

    function automatic void note_write(logic [15:0] a, logic [7:0] d);
        wr_a[wr_n] = a;
        wr_d[wr_n] = d;
        wr_n++;
    endfunction

    function automatic void push_byte(logic [7:0] d);
        note_write({c6502_pkg::STACK_PAGE, cpu_sp}, d);
        cpu_sp = cpu_sp - 8'd1;
    endfunction

    function automatic void add_with_carry(logic [7:0] m);
        logic [8:0] sum;
        sum = {1'b0, cpu_a} + {1'b0, m} + {8'd0, cpu_p[c6502_pkg::FLAG_C]};
        cpu_p[c6502_pkg::FLAG_C] = sum[8];
        cpu_p[c6502_pkg::FLAG_V] = ~(cpu_a[7] ^ m[7]) & (cpu_a[7] ^ sum[7]);
        cpu_a = sum[7:0];
        put_nz(cpu_a);
    endfunction

    function automatic void compare_reg(logic [7:0] r, logic [7:0] m);
        put_nz(r - m);
        cpu_p[c6502_pkg::FLAG_C] = (r >= m);
    endfunction

    function automatic void execute_instr(instr_t it);
        logic [7:0]  v, r;
        logic [15:0] t;
        logic        cin, take;
        bit          is_branch;
        effect_t     e;
        int          n;
        wr_n = 0;
        is_branch = 0;
        take = 0;
        cpu_pc = it.npc;
        cin = cpu_p[c6502_pkg::FLAG_C];
        case (it.cmd)
            c6502_pkg::OP_LDA: begin cpu_a = it.m; put_nz(it.m); end
            c6502_pkg::OP_LDX: begin cpu_x = it.m; put_nz(it.m); end
            c6502_pkg::OP_LDY: begin cpu_y = it.m; put_nz(it.m); end
            c6502_pkg::OP_STA: note_write(it.ea, cpu_a);
            c6502_pkg::OP_STX: note_write(it.ea, cpu_x);
            c6502_pkg::OP_STY: note_write(it.ea, cpu_y);
            c6502_pkg::OP_TAX: begin cpu_x = cpu_a; put_nz(cpu_x); end
            c6502_pkg::OP_TAY: begin cpu_y = cpu_a; put_nz(cpu_y); end
            c6502_pkg::OP_TXA: begin cpu_a = cpu_x; put_nz(cpu_a); end
            c6502_pkg::OP_TYA: begin cpu_a = cpu_y; put_nz(cpu_a); end
            c6502_pkg::OP_TSX: begin cpu_x = cpu_sp; put_nz(cpu_x); end
            c6502_pkg::OP_TXS: cpu_sp = cpu_x;
            c6502_pkg::OP_PHA: push_byte(cpu_a);
            c6502_pkg::OP_PHP: push_byte(cpu_p | 8'h30);
            c6502_pkg::OP_PLA: begin
                cpu_sp = cpu_sp + 8'd1; cpu_a = it.b1; put_nz(it.b1);
            end
            c6502_pkg::OP_PLP: begin
                cpu_sp = cpu_sp + 8'd1; cpu_p = (it.b1 & 8'hEF) | 8'h20;
            end
            c6502_pkg::OP_AND: begin cpu_a = cpu_a & it.m; put_nz(cpu_a); end
            c6502_pkg::OP_EOR: begin cpu_a = cpu_a ^ it.m; put_nz(cpu_a); end
            c6502_pkg::OP_ORA: begin cpu_a = cpu_a | it.m; put_nz(cpu_a); end
            c6502_pkg::OP_BIT: begin
                cpu_p[c6502_pkg::FLAG_Z] = ((cpu_a & it.m) == 8'h00);
                cpu_p[c6502_pkg::FLAG_N] = it.m[7];
                cpu_p[c6502_pkg::FLAG_V] = it.m[6];
            end
            c6502_pkg::OP_ADC: add_with_carry(it.m);
            c6502_pkg::OP_SBC: add_with_carry(~it.m);
            c6502_pkg::OP_CMP: compare_reg(cpu_a, it.m);
            c6502_pkg::OP_CPX: compare_reg(cpu_x, it.m);
            c6502_pkg::OP_CPY: compare_reg(cpu_y, it.m);
            c6502_pkg::OP_INC: begin
                r = it.m + 8'd1; put_nz(r); note_write(it.ea, r);
            end
            c6502_pkg::OP_INX: begin cpu_x = cpu_x + 8'd1; put_nz(cpu_x); end
            c6502_pkg::OP_INY: begin cpu_y = cpu_y + 8'd1; put_nz(cpu_y); end
            c6502_pkg::OP_DEC: begin
                r = it.m - 8'd1; put_nz(r); note_write(it.ea, r);
            end
            c6502_pkg::OP_DEX: begin cpu_x = cpu_x - 8'd1; put_nz(cpu_x); end
            c6502_pkg::OP_DEY: begin cpu_y = cpu_y - 8'd1; put_nz(cpu_y); end
            c6502_pkg::OP_ASL, c6502_pkg::OP_LSR,
            c6502_pkg::OP_ROL, c6502_pkg::OP_ROR: begin
                v = it.accm ? cpu_a : it.m;
                if (it.cmd == c6502_pkg::OP_ASL || it.cmd == c6502_pkg::OP_ROL) begin
                    r = {v[6:0], (it.cmd == c6502_pkg::OP_ROL) ? cin : 1'b0};
                    cpu_p[c6502_pkg::FLAG_C] = v[7];
                end else begin
                    r = {(it.cmd == c6502_pkg::OP_ROR) ? cin : 1'b0, v[7:1]};
                    cpu_p[c6502_pkg::FLAG_C] = v[0];
                end
                put_nz(r);
                if (it.accm) cpu_a = r;
                else note_write(it.ea, r);
            end
            c6502_pkg::OP_JMP: cpu_pc = it.ea;
            c6502_pkg::OP_JSR: begin
                t = it.npc - 16'd1;
                push_byte(t[15:8]);
                push_byte(t[7:0]);
                cpu_pc = it.ea;
            end
            c6502_pkg::OP_RTS: begin
                cpu_sp = cpu_sp + 8'd2; cpu_pc = {it.b2, it.b1} + 16'd1;
            end
            c6502_pkg::OP_BCC: begin is_branch = 1; take = ~cpu_p[c6502_pkg::FLAG_C]; end
            c6502_pkg::OP_BCS: begin is_branch = 1; take = cpu_p[c6502_pkg::FLAG_C]; end
            c6502_pkg::OP_BEQ: begin is_branch = 1; take = cpu_p[c6502_pkg::FLAG_Z]; end
            c6502_pkg::OP_BMI: begin is_branch = 1; take = cpu_p[c6502_pkg::FLAG_N]; end
            c6502_pkg::OP_BNE: begin is_branch = 1; take = ~cpu_p[c6502_pkg::FLAG_Z]; end
            c6502_pkg::OP_BPL: begin is_branch = 1; take = ~cpu_p[c6502_pkg::FLAG_N]; end
            c6502_pkg::OP_BVC: begin is_branch = 1; take = ~cpu_p[c6502_pkg::FLAG_V]; end
            c6502_pkg::OP_BVS: begin is_branch = 1; take = cpu_p[c6502_pkg::FLAG_V]; end
            c6502_pkg::OP_CLC: cpu_p[c6502_pkg::FLAG_C] = 1'b0;
            c6502_pkg::OP_CLD: cpu_p[c6502_pkg::FLAG_D] = 1'b0;
            c6502_pkg::OP_CLI: cpu_p[c6502_pkg::FLAG_I] = 1'b0;
            c6502_pkg::OP_CLV: cpu_p[c6502_pkg::FLAG_V] = 1'b0;
            c6502_pkg::OP_SEC: cpu_p[c6502_pkg::FLAG_C] = 1'b1;
            c6502_pkg::OP_SED: cpu_p[c6502_pkg::FLAG_D] = 1'b1;
            c6502_pkg::OP_SEI: cpu_p[c6502_pkg::FLAG_I] = 1'b1;
            c6502_pkg::OP_BRK: begin
                t = it.npc + 16'd1;
                push_byte(t[15:8]);
                push_byte(t[7:0]);
                push_byte(cpu_p | 8'h30);
                cpu_p[c6502_pkg::FLAG_I] = 1'b1;
                cpu_pc = it.vec;
            end
            c6502_pkg::OP_RTI: begin
                cpu_sp = cpu_sp + 8'd3;
                cpu_p = (it.b1 & 8'hEF) | 8'h20;
                cpu_pc = {it.b3, it.b2};
            end
            default: ;
        endcase
        if (is_branch && take) cpu_pc = it.ea;
        n = (wr_n > 0) ? wr_n : 1;
        for (int k = 0; k < n; k++) begin
            e.wvalid = (k < wr_n);
            e.waddr  = e.wvalid ? wr_a[k] : 16'h0;
            e.wdata  = e.wvalid ? wr_d[k] : 8'h0;
            e.pc = cpu_pc; e.acc = cpu_a; e.x = cpu_x; e.y = cpu_y;
            e.sp = cpu_sp; e.p = cpu_p;
            e.last = (k == n - 1);
            expected_effects.push_back(e);
        end
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic instr_t rand_instr(logic [5:0] op);
        instr_t it;
        it.cmd = op;
        it.accm = 1'($urandom_range(0, 1));
        it.m = 8'($urandom);
        it.ea = 16'($urandom);
        it.npc = 16'($urandom);
        it.b1 = 8'($urandom);
        it.b2 = 8'($urandom);
        it.b3 = 8'($urandom);
        it.vec = 16'($urandom);
        return it;
    endfunction

    function automatic instr_t with_op(logic [5:0] op, logic [7:0] m, logic accm);
        instr_t it;
        it = rand_instr(op);
        it.m = m;
        it.accm = accm;
        return it;
    endfunction

    // a request offered at the last rising edge was taken there
    always @(posedge aclk) begin
        in_taken <= s_tvalid && s_tready;
    end

    // sender: inputs change on the falling edge
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && !in_taken) begin
                // hold the request until it is taken
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_instrs.size() > 0) begin
                if (!calm && $urandom_range(0, 9) == 0) begin
                    send_gap <= $urandom_range(1, 15);
                    s_tvalid <= 1'b0;
                end else begin
                    s_tdata <= {1'b0, pending_instrs.pop_front()};
                    s_tvalid <= 1'b1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: ready changes on the falling edge, long hold-off counted here
    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_req && !hold_done) begin
                hold_done <= 1'b1;
                hold_off <= HOLD_CYCLES;
                m_tready <= 1'b0;
            end else if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                recv_gap <= $urandom_range(1, 15);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // monitor: prediction at input acceptance, checking at output acceptance
    always @(posedge aclk) begin
        effect_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                execute_instr(instr_t'(s_tdata[86:0]));
            if (m_tvalid && m_tready) begin
                if (expected_effects.size() == 0) begin
                    report_mismatch("unexpected result", 16'h0, 16'h0);
                end else begin
                    want = expected_effects.pop_front();
                    if (m_tdata[0] !== want.wvalid)
                        report_mismatch("write_valid", m_tdata[0], want.wvalid);
                    if (m_tdata[16:1] !== want.waddr)
                        report_mismatch("write_addr", m_tdata[16:1], want.waddr);
                    if (m_tdata[24:17] !== want.wdata)
                        report_mismatch("write_data", m_tdata[24:17], want.wdata);
                    if (m_tdata[40:25] !== want.pc)
                        report_mismatch("pc_out", m_tdata[40:25], want.pc);
                    if (m_tdata[48:41] !== want.acc)
                        report_mismatch("acc_out", m_tdata[48:41], want.acc);
                    if (m_tdata[56:49] !== want.x)
                        report_mismatch("x_out", m_tdata[56:49], want.x);
                    if (m_tdata[64:57] !== want.y)
                        report_mismatch("y_out", m_tdata[64:57], want.y);
                    if (m_tdata[72:65] !== want.sp)
                        report_mismatch("sp_out", m_tdata[72:65], want.sp);
                    if (m_tdata[80:73] !== want.p)
                        report_mismatch("status_out", m_tdata[80:73], want.p);
                    if (m_tlast !== want.last)
                        report_mismatch("last", m_tlast, want.last);
                end
            end
        end
    end

    // watchdog on cycles with no request or result moving
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired at %0t", $realtime);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        logic [5:0] op;
        int r;
        cpu_a = 8'h00; cpu_x = 8'h00; cpu_y = 8'h00;
        cpu_sp = c6502_pkg::SP_RESET; cpu_pc = 16'h0000; cpu_p = c6502_pkg::P_RESET;
        // directed: extremes, flag corner cases, stack wrap, every operation
        pending_instrs.push_back(with_op(c6502_pkg::OP_LDA, 8'h00, 0));
        pending_instrs.push_back(with_op(c6502_pkg::OP_LDA, 8'hFF, 1));
        pending_instrs.push_back(with_op(c6502_pkg::OP_ADC, 8'h01, 0));
        pending_instrs.push_back(with_op(c6502_pkg::OP_LDA, 8'h7F, 0));
        pending_instrs.push_back(with_op(c6502_pkg::OP_ADC, 8'h01, 0));
        pending_instrs.push_back(with_op(c6502_pkg::OP_SBC, 8'hFF, 0));
        pending_instrs.push_back(with_op(c6502_pkg::OP_BIT, 8'hC0, 0));
        pending_instrs.push_back(with_op(c6502_pkg::OP_ROL, 8'h80, 1));
        pending_instrs.push_back(with_op(c6502_pkg::OP_ROR, 8'h01, 0));
        pending_instrs.push_back(with_op(c6502_pkg::OP_LDX, 8'h00, 0));
        pending_instrs.push_back(with_op(c6502_pkg::OP_TXS, 8'h00, 0));
        pending_instrs.push_back(with_op(c6502_pkg::OP_BRK, 8'h00, 0));
        pending_instrs.push_back(with_op(c6502_pkg::OP_RTI, 8'hFF, 0));
        pending_instrs.push_back(with_op(c6502_pkg::OP_JSR, 8'h00, 0));
        pending_instrs.push_back(with_op(c6502_pkg::OP_RTS, 8'h00, 0));
        pending_instrs.push_back(with_op(c6502_pkg::OP_PLP, 8'hFF, 0));
        pending_instrs.push_back(with_op(c6502_pkg::OP_PHP, 8'h00, 0));
        pending_instrs.push_back(with_op(6'd63, 8'hFF, 1));
        for (int k = 0; k <= c6502_pkg::OP_RTI; k++)
            pending_instrs.push_back(rand_instr(k[5:0]));
        // random part: mostly valid operations, a few unused codes
        for (int k = 0; k < 56; k++) begin
            r = $urandom_range(0, 19);
            op = (r == 0) ? 6'($urandom_range(56, 63)) : 6'($urandom_range(0, 55));
            pending_instrs.push_back(rand_instr(op));
        end
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        // long receiver hold-off so the block fills and stalls its input
        repeat (40) @(posedge aclk);
        @(negedge aclk);
        hold_req = 1'b1;
        wait (pending_instrs.size() < 40);
        calm = 1;
        wait (pending_instrs.size() == 0 && !s_tvalid);
        @(posedge aclk);
        wait (expected_effects.size() == 0);
        repeat (20) @(posedge aclk);
        if (error_count == 0 && expected_effects.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### cpu6502_execute_unit.f
hw/rtl/c6502_pkg.sv
hw/rtl/c6502_alu.sv
hw/rtl/cpu6502_execute_unit.sv
sim/cpu6502_execute_unit_tb.sv
